### rtl/core/scp_pkg.sv
// Shared types, constants and request codes for the saturated cost partition block.
// Depends on nothing; scp_update and the top level import it.
`timescale 1ns / 1ps
`default_nettype none

package scp_pkg;

   localparam int STATE_COUNT = 1024;
   localparam int NUM_OPS     = 1024;
   localparam int DIST_BITS   = 20;

   localparam int SIDX_W     = (STATE_COUNT > 1) ? $clog2(STATE_COUNT) : 1;
   localparam int OIDX_W     = (NUM_OPS > 1) ? $clog2(NUM_OPS) : 1;
   localparam int SAT_W      = DIST_BITS + 1;
   localparam int REM_CALC_W = DIST_BITS + 2;

   // request function codes
   localparam logic [2:0] FN_LOAD_STATE = 3'd0;
   localparam logic [2:0] FN_LOAD_OP    = 3'd1;
   localparam logic [2:0] FN_TRANS      = 3'd2;
   localparam logic [2:0] FN_SELF       = 3'd3;
   localparam logic [2:0] FN_REDUCE     = 3'd4;

   // reduce status codes
   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_UNDER = 2'd1;
   localparam logic [1:0] STAT_OVER  = 2'd2;

   typedef struct packed {
      logic [2:0]  func;
      logic [9:0]  src_idx;
      logic [9:0]  dst_idx;
      logic [9:0]  op_index;
      logic [19:0] init_dist;
      logic        init_dist_inf;
      logic [19:0] goal_dist;
      logic        goal_dist_inf;
      logic [19:0] op_cost;
      logic        op_cost_inf;
   } req_type;

   typedef struct packed {
      logic signed [20:0] saturated;
      logic               saturated_neg_inf;
      logic [19:0]        remaining;
      logic               remaining_inf;
      logic [1:0]         status;
   } rsp_type;

   // one word of the state memory
   typedef struct packed {
      logic                 init_inf;
      logic                 goal_inf;
      logic [DIST_BITS-1:0] goal;
   } state_word_type;

   // one word of the operator memory
   typedef struct packed {
      logic                    sat_valid;
      logic signed [SAT_W-1:0] sat;
      logic                    rem_inf;
      logic [DIST_BITS-1:0]    rem;
   } op_word_type;

   localparam int SWORD_W = $bits(state_word_type);
   localparam int OWORD_W = $bits(op_word_type);

   typedef struct packed {
      logic [2:0]     func;
      logic           general;
      logic           src_ok;
      logic           tgt_ok;
      logic           op_ok;
      state_word_type src;
      state_word_type tgt;
      op_word_type    op;
      logic [19:0]    op_cost;
      logic           op_cost_inf;
   } upd_in_type;

   typedef struct packed {
      logic        we;
      op_word_type wr;
      rsp_type     rsp;
   } upd_out_type;

endpackage

`default_nettype wire

### rtl/core/scp_ram.sv
// Generic single-port synchronous RAM with registered read data.
// Read-first on a write to the same address. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module scp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                   clock,
   input  wire logic                                   we,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
   input  wire logic [WIDTH-1:0]                       wdata,
   output logic [WIDTH-1:0]                            rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

### rtl/core/scp_update.sv
// Operator word update: raise of the saturated cost, load and reduction of the
// remaining cost, and the response fields. Uses scp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module scp_update
   import scp_pkg::*;
(
   input  wire upd_in_type u,
   output upd_out_type     o
);

   localparam logic signed [REM_CALC_W-1:0] R_MAX = {2'b00, {DIST_BITS{1'b1}}};

   logic signed [SAT_W-1:0]      need;
   logic signed [SAT_W-1:0]      raise_v;
   logic signed [SAT_W-1:0]      sat_cur;
   logic signed [SAT_W-1:0]      raised;
   logic signed [SAT_W-1:0]      s_eff;
   logic signed [REM_CALC_W-1:0] diff;
   logic                         neg_inf;
   logic                         new_inf;
   logic [DIST_BITS-1:0]         new_rem;
   logic [1:0]                   status;

   always_comb begin
      need    = $signed({1'b0, u.src.goal}) - $signed({1'b0, u.tgt.goal});
      raise_v = (u.func == FN_TRANS) ? need : '0;
      sat_cur = u.op.sat;

      // empty entry takes the new value, floored at zero without general costs
      if (!u.op.sat_valid) begin
         raised = (!u.general && (raise_v < 0)) ? '0 : raise_v;
      end else begin
         raised = (raise_v > sat_cur) ? raise_v : sat_cur;
      end

      neg_inf = !u.op.sat_valid && u.general;
      s_eff   = u.op.sat_valid ? sat_cur : '0;
      diff    = $signed({2'b00, u.op.rem}) - $signed({s_eff[SAT_W-1], s_eff});

      new_inf = u.op.rem_inf;
      new_rem = u.op.rem;
      status  = STAT_OK;
      if (u.op.rem_inf) begin
         new_inf = 1'b1;
      end else if (neg_inf) begin
         new_inf = 1'b1;
         new_rem = '0;
      end else if (diff < 0) begin
         new_rem = '0;
         status  = STAT_UNDER;
      end else if (diff > R_MAX) begin
         new_rem = {DIST_BITS{1'b1}};
         status  = STAT_OVER;
      end else begin
         new_rem = diff[DIST_BITS-1:0];
      end

      o.we  = 1'b0;
      o.wr  = u.op;
      o.rsp = '0;

      case (u.func)
         FN_LOAD_OP: begin
            o.we        = u.op_ok;
            o.wr.rem_inf = u.op_cost_inf;
            o.wr.rem     = u.op_cost_inf ? '0 : DIST_BITS'(u.op_cost);
         end
         FN_TRANS: begin
            o.we = u.src_ok && u.tgt_ok && u.op_ok && !u.src.init_inf &&
                   !u.src.goal_inf && !u.tgt.goal_inf;
            o.wr.sat_valid = 1'b1;
            o.wr.sat       = raised;
         end
         FN_SELF: begin
            o.we = u.general && u.src_ok && u.op_ok && !u.src.init_inf &&
                   !u.src.goal_inf;
            o.wr.sat_valid = 1'b1;
            o.wr.sat       = raised;
         end
         FN_REDUCE: begin
            if (u.op_ok) begin
               o.we                    = 1'b1;
               o.wr.sat_valid          = 1'b0;
               o.wr.sat                = '0;
               o.wr.rem_inf            = new_inf;
               o.wr.rem                = new_inf ? '0 : new_rem;
               o.rsp.saturated         = neg_inf ? '0 : 21'(s_eff);
               o.rsp.saturated_neg_inf = neg_inf;
               o.rsp.remaining         = new_inf ? '0 : 20'(new_rem);
               o.rsp.remaining_inf     = new_inf;
               o.rsp.status            = status;
            end
         end
         default: begin
         end
      endcase
   end

endmodule

`default_nettype wire

### rtl/core/saturated_cost_partition_top.sv
// Top level of the saturated cost partition block: sequencer, state and operator
// memories, response register. Uses scp_pkg, scp_ram and scp_update.
//
//   channel   ports                          direction  handshake
//   request   start, busy, req_data          in         start high while busy low
//   response  rsp_valid, rsp_data            out        one-cycle strobe, no stall
//   config    csr_valid, csr_ready, csr_data in         valid and ready both high
//
// Every request gives exactly one response. A transition passes through ST_READ
// and then ST_TGT before its response is registered, because of the two
// goal-distance reads on the single state memory port; every other request ends
// in ST_READ (one read of the operator memory, then its write-back).
// After reset a pass over all NUM_OPS (1024) words clears the operator memory;
// busy stays high meanwhile. Config writes are taken at any time.
// The response strobe may coincide with the next request's acceptance; the receiver
// cannot stall, so busy is the only back-pressure.
`timescale 1ns / 1ps
`default_nettype none

module saturated_cost_partition_top
   import scp_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_data,
   output logic         rsp_valid,
   output rsp_type      rsp_data,
   input  wire logic    csr_valid,
   output logic         csr_ready,
   input  wire logic    csr_data
);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_TGT
   } fsm_type;

   fsm_type        state_ff, state_in;
   logic [OIDX_W-1:0] clr_cnt_ff, clr_cnt_in;
   req_type        req_ff, req_in;
   state_word_type src_ff, src_in;
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_type        rsp_ff, rsp_in;
   logic           general_ff;

   logic [SIDX_W-1:0]  state_addr;
   logic               state_we;
   logic [SWORD_W-1:0] state_wdata;
   logic [SWORD_W-1:0] state_rdata;
   state_word_type     state_rd;
   state_word_type     state_wr;

   logic [OIDX_W-1:0]  op_addr;
   logic               op_we;
   logic [OWORD_W-1:0] op_wdata;
   logic [OWORD_W-1:0] op_rdata;

   upd_in_type  upd_in;
   upd_out_type upd_out;

   logic is_trans;
   logic finish;

   assign is_trans = (req_ff.func == FN_TRANS);
   assign state_rd = state_rdata;

   // memories
   scp_ram #(
      .WIDTH (SWORD_W),
      .DEPTH (STATE_COUNT)
   ) u_state_ram (
      .clock (clock),
      .we    (state_we),
      .addr  (state_addr),
      .wdata (state_wdata),
      .rdata (state_rdata)
   );

   scp_ram #(
      .WIDTH (OWORD_W),
      .DEPTH (NUM_OPS)
   ) u_op_ram (
      .clock (clock),
      .we    (op_we),
      .addr  (op_addr),
      .wdata (op_wdata),
      .rdata (op_rdata)
   );

   // address the source and operator straight from the request port so the
   // read data lands in the first busy cycle
   always_comb begin
      case (state_ff)
         ST_IDLE: begin
            state_addr = SIDX_W'(req_data.src_idx);
            op_addr    = OIDX_W'(req_data.op_index);
         end
         ST_CLEAR: begin
            state_addr = SIDX_W'(req_ff.src_idx);
            op_addr    = clr_cnt_ff;
         end
         ST_READ: begin
            // fetch the target while the source data is on the read port
            state_addr = is_trans ? SIDX_W'(req_ff.dst_idx) : SIDX_W'(req_ff.src_idx);
            op_addr    = OIDX_W'(req_ff.op_index);
         end
         default: begin
            state_addr = SIDX_W'(req_ff.src_idx);
            op_addr    = OIDX_W'(req_ff.op_index);
         end
      endcase
   end

   assign state_wr.init_inf = req_ff.init_dist_inf;
   assign state_wr.goal_inf = req_ff.goal_dist_inf;
   assign state_wr.goal     = DIST_BITS'(req_ff.goal_dist);
   assign state_wdata       = state_wr;
   assign state_we          = (state_ff == ST_READ) && (req_ff.func == FN_LOAD_STATE) &&
                              (32'(req_ff.src_idx) < STATE_COUNT);

   // operator word update
   always_comb begin
      upd_in.func        = req_ff.func;
      upd_in.general     = general_ff;
      upd_in.src_ok      = 32'(req_ff.src_idx) < STATE_COUNT;
      upd_in.tgt_ok      = 32'(req_ff.dst_idx) < STATE_COUNT;
      upd_in.op_ok       = 32'(req_ff.op_index) < NUM_OPS;
      upd_in.src         = (state_ff == ST_TGT) ? src_ff : state_rd;
      upd_in.tgt         = state_rd;
      upd_in.op          = op_rdata;
      upd_in.op_cost     = req_ff.op_cost;
      upd_in.op_cost_inf = req_ff.op_cost_inf;
   end

   scp_update u_update (
      .u (upd_in),
      .o (upd_out)
   );

   // the operator word read at acceptance stays on the read port until the
   // write-back, since the address holds
   assign finish = ((state_ff == ST_READ) && !is_trans) || (state_ff == ST_TGT);

   always_comb begin
      if (state_ff == ST_CLEAR) begin
         op_we    = 1'b1;
         op_wdata = '0;
      end else begin
         op_we    = finish && upd_out.we;
         op_wdata = upd_out.wr;
      end
   end

   // sequencer next state
   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      req_in       = req_ff;
      src_in       = src_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_cnt_in = OIDX_W'(clr_cnt_ff + 1'b1);
            if (clr_cnt_ff == OIDX_W'(NUM_OPS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               req_in   = req_data;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            // hold the source word for the transition's second read
            src_in = state_rd;
            if (is_trans) begin
               state_in = ST_TGT;
            end
         end
         default: begin
         end
      endcase
      if (finish) begin
         rsp_valid_in = 1'b1;
         rsp_in       = upd_out.rsp;
         state_in     = ST_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         general_ff   <= 1'b1;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            general_ff <= csr_data;
         end
      end
      req_ff <= req_in;
      src_ff <= src_in;
      rsp_ff <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // a response never follows its own request in the next cycle
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> !rsp_valid)
      else $error("response strobe one cycle after acceptance");

   // responses only come out of the two finishing states
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(state_ff) == ST_READ || $past(state_ff) == ST_TGT))
      else $error("response strobe without a finished request");

   // the second read phase belongs to transitions only
   a_tgt_trans: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TGT) |-> (req_ff.func == FN_TRANS))
      else $error("target phase for a request that is no transition");

   // no operator write while waiting for a request
   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !op_we)
      else $error("operator memory written while idle");

endmodule

`default_nettype wire
